/* hdl/sfcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcr_pkg
// Shared types and constants for the sensor frame checksum receiver.
// ----------------------------------------------------------------------------
package sfcr_pkg;

  // Byte position counter width and its saturation value
  localparam int          POS_W       = 4;
  localparam logic [3:0]  POS_MAX     = 4'd15;

  // Default minimum frame length (legal range 9..16)
  localparam int          FRAME_LEN_DEF = 9;

  // Frame layout
  localparam logic [7:0]  START_MARK  = 8'hFF;
  localparam logic [3:0]  HIGH_POS    = 4'd6;
  localparam logic [3:0]  LOW_POS     = 4'd7;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_START = 2'd2,
    ST_BAD_SUM   = 2'd3
  } sfcr_status_t;

  // One result transaction
  typedef struct packed {
    sfcr_status_t status;
    logic [15:0]  concentration;
  } sfcr_result_t;

endpackage

/* hdl/sfcr_frame_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcr_frame_track
// Per-byte chunk state (position, start byte, running sum, reading bytes)
// and the end-of-chunk frame check.
// ----------------------------------------------------------------------------
module sfcr_frame_track #(
  parameter int FRAME_LEN = sfcr_pkg::FRAME_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_acc,
  input  logic [7:0]           rx_byte,
  input  logic                 chunk_last,
  output logic                 res_valid,
  output sfcr_pkg::sfcr_result_t res
);

  localparam logic [sfcr_pkg::POS_W-1:0] MIN_LAST_POS =
    sfcr_pkg::POS_W'(FRAME_LEN - 1);

  logic [sfcr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] held_r, held_nxt;

  logic [7:0]  first_byte;
  logic [7:0]  expect_sum;
  sfcr_pkg::sfcr_status_t status;

  // Frame check, first failing test wins
  always_comb begin
    first_byte = (pos_r == '0) ? rx_byte : start_r;
    expect_sum = 8'(8'd0 - sum_r);
    priority if (pos_r < MIN_LAST_POS) begin
      status = sfcr_pkg::ST_SHORT;
    end else if (first_byte != sfcr_pkg::START_MARK) begin
      status = sfcr_pkg::ST_BAD_START;
    end else if (rx_byte != expect_sum) begin
      status = sfcr_pkg::ST_BAD_SUM;
    end else begin
      status = sfcr_pkg::ST_OK;
    end
  end

  // Next state
  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    sum_nxt   = sum_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    held_nxt  = held_r;
    if (byte_acc) begin
      if (chunk_last) begin
        pos_nxt   = '0;
        start_nxt = '0;
        sum_nxt   = '0;
        high_nxt  = '0;
        low_nxt   = '0;
        if (status == sfcr_pkg::ST_OK) begin
          held_nxt = {high_r, low_r};
        end
      end else begin
        if (pos_r == '0) begin
          start_nxt = rx_byte;
        end else begin
          sum_nxt = sum_r + rx_byte;
        end
        if (pos_r == sfcr_pkg::HIGH_POS) begin
          high_nxt = rx_byte;
        end
        if (pos_r == sfcr_pkg::LOW_POS) begin
          low_nxt = rx_byte;
        end
        if (pos_r != sfcr_pkg::POS_MAX) begin
          pos_nxt = pos_r + sfcr_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      sum_r   <= '0;
      high_r  <= '0;
      low_r   <= '0;
      held_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      sum_r   <= sum_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      held_r  <= held_nxt;
    end
  end

  // Result goes out on the last byte, reporting the updated reading
  assign res_valid         = byte_acc && chunk_last;
  assign res.status        = status;
  assign res.concentration = held_nxt;

  // Position restarts after every chunk end
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    byte_acc && chunk_last |=> pos_r == '0)
    else $error("position not cleared after chunk end");

  // Position advances by one on a middle byte below saturation
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    byte_acc && !chunk_last && pos_r != sfcr_pkg::POS_MAX
      |=> pos_r == $past(pos_r) + sfcr_pkg::POS_W'(1))
    else $error("position did not advance");

  // Held reading only changes on an accepted frame
  a_held_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != $past(held_r)
      |-> $past(res_valid) && $past(res.status) == sfcr_pkg::ST_OK)
    else $error("held reading changed without accepted frame");

endmodule

/* hdl/sfcr_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcr_out_reg
// Output register holding one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module sfcr_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  sfcr_pkg::sfcr_result_t res,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output sfcr_pkg::sfcr_result_t out_res,
  output logic                   slot_free
);

  logic                   valid_r;
  sfcr_pkg::sfcr_result_t data_r;

  // Slot is free when empty or drained this cycle
  assign slot_free = !valid_r || out_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = data_r;

endmodule

/* hdl/sensor_frame_checksum_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_checksum_receiver
// Checks gas sensor frames byte by byte and reports status and reading.
// ----------------------------------------------------------------------------
//  Channel | Dir | Signals                       | Content
//  in_     | in  | tvalid tready tdata[7:0] tlast | rx_byte, chunk_last
//  out_    | out | tvalid tready tdata[15:0] tuser| concentration, frame_status
//
// One byte per cycle; the running sum and position counter update in the
// cycle a byte is taken, and the result lands in the output register in
// the cycle after the last byte. Middle bytes are taken even while a result
// waits; a last byte waits until the output register is free or draining.
// Synchronous active-low reset clears chunk state, held reading, out valid.
// ----------------------------------------------------------------------------
module sensor_frame_checksum_receiver #(
  parameter int FRAME_LEN = sfcr_pkg::FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // chunk_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] concentration
  output logic [1:0]  out_tuser   // [1:0] frame_status
);

  logic                   byte_acc;
  logic                   res_valid;
  logic                   slot_free;
  sfcr_pkg::sfcr_result_t res;
  sfcr_pkg::sfcr_result_t out_res;

  assign in_tready = slot_free || !in_tlast;
  assign byte_acc  = in_tvalid && in_tready;

  sfcr_frame_track #(
    .FRAME_LEN (FRAME_LEN)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .rx_byte    (in_tdata),
    .chunk_last (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfcr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .slot_free  (slot_free)
  );

  assign out_tdata = out_res.concentration;
  assign out_tuser = out_res.status;

  // A last byte always yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last byte");

endmodule
